// ===== hw/rtl/hsfe_pkg.sv =====
// Shared types and constants for the header sync frame extractor.
// Used by the channel interfaces, the front, queue and back stages and the top level.
// Depends on nothing.
package hsfe_pkg;

   // Field widths.
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 32;
   localparam int LEN_W    = 12;
   localparam int HDR_LEN  = 4;
   localparam int BEAT_W   = $clog2(HDR_LEN);

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = WORD_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_HEADER  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH = CSR_INDEX_W'(1);

   // Register reset values.
   localparam logic [WORD_W-1:0] SYNC_HEADER_RESET  = 32'hAA55_5AA5;
   localparam logic [LEN_W-1:0]  FRAME_LENGTH_RESET = LEN_W'(110);

   // Command queue between the front and back stages.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [WORD_W-1:0] sync_header;
      logic [LEN_W-1:0]  frame_length;
   } cfg_type;

   typedef enum logic {
      ENTRY_DATA,
      ENTRY_HEADER
   } entry_kind_type;

   // One queued command: a single frame byte, or a whole header to be expanded.
   typedef struct packed {
      entry_kind_type    kind;
      logic [WORD_W-1:0] word;
      logic              last;
      logic [LEN_W-1:0]  pos;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_slot_type;

   typedef struct packed {
      logic              full;
      logic [QCNT_W-1:0] count;
   } q_status_type;

endpackage

// ===== hw/rtl/hsfe_req_if.sv =====
// Input channel: one received byte per item with a valid/ready handshake.
// Depends on hsfe_pkg.
interface hsfe_req_if;
   logic                        valid;
   logic                        ready;
   logic [hsfe_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/hsfe_rsp_if.sv =====
// Result channel: one frame byte per item with its last flag and position.
// Depends on hsfe_pkg.
interface hsfe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hsfe_pkg::BYTE_W-1:0] frame_byte;
   logic                        frame_last;
   logic [hsfe_pkg::LEN_W-1:0]  byte_position;

   modport source (output valid, output frame_byte, output frame_last,
                   output byte_position, input ready);
   modport sink   (input valid, input frame_byte, input frame_last,
                   input byte_position, output ready);
endinterface

// ===== hw/rtl/header_sync_frame_extractor.sv =====
// A frame byte passes through a queue slot and the output register to rsp_ch.
// Throughput: one byte per cycle in while a slot is free; the back stage emits one item
// per cycle while rsp_ch is ready; the four-entry queue absorbs the header burst.
// Reset (synchronous, active high) empties the queue and output register, restarts the
// hunt with an empty window, and sets sync_header to AA55_5AA5 and frame_length to 110.
module header_sync_frame_extractor (
   input  logic                                 clock,
   input  logic                                 reset,
   hsfe_req_if.sink                             req_ch,
   hsfe_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [hsfe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hsfe_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   hsfe_pkg::cfg_type      cfg_ff, cfg_in;
   hsfe_pkg::q_slot_type   push;
   hsfe_pkg::q_slot_type   head;
   hsfe_pkg::q_status_type q_stat;
   logic                   pop;

   // Configuration register writes; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            hsfe_pkg::CSR_SYNC_HEADER:  cfg_in.sync_header  = csr_wdata;
            hsfe_pkg::CSR_FRAME_LENGTH: cfg_in.frame_length = csr_wdata[hsfe_pkg::LEN_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_header  <= hsfe_pkg::SYNC_HEADER_RESET;
         cfg_ff.frame_length <= hsfe_pkg::FRAME_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hsfe_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .cfg    (cfg_ff),
      .q_stat (q_stat),
      .push   (push)
   );

   hsfe_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_stat)
   );

   hsfe_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

   // The queue never holds more commands than it has slots.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= hsfe_pkg::QCNT_W'(hsfe_pkg::QUEUE_DEPTH))
      else $error("command queue over capacity");

   // Nothing is presented in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid right after reset");

   // A frame ends no earlier than the last header byte.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.frame_last) |->
         (rsp_ch.byte_position >= hsfe_pkg::LEN_W'(hsfe_pkg::HDR_LEN - 1)))
      else $error("frame ended inside the header");

   // A full queue is not drained without a pop.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (q_stat.full && !pop) |=> (q_stat.count != '0))
      else $error("queue drained without a pop");

endmodule

// ===== hw/rtl/hsfe_front.sv =====
// Front stage: accepts received bytes, hunts for the sync header and tracks the frame.
// Pushes one command per header or frame byte into the queue. Depends on hsfe_pkg, hsfe_req_if.
module hsfe_front (
   input  logic                  clock,
   input  logic                  reset,
   hsfe_req_if.sink              req,
   input  hsfe_pkg::cfg_type     cfg,
   input  hsfe_pkg::q_status_type q_stat,
   output hsfe_pkg::q_slot_type  push
);

   logic [hsfe_pkg::BYTE_W-1:0] recent_ff [3];
   logic [hsfe_pkg::BYTE_W-1:0] recent_in [3];
   logic [1:0]                  fill_ff, fill_in;
   logic                        in_frame_ff, in_frame_in;
   logic [hsfe_pkg::LEN_W-1:0]  emitted_ff, emitted_in;

   logic                          accept;
   logic [hsfe_pkg::LEN_W-1:0]    len;
   logic [hsfe_pkg::LEN_W:0]      pos_next;
   logic                          data_last;
   logic                          hdr_last;
   logic [hsfe_pkg::WORD_W-1:0]   window;
   logic                          match;

   // The queue sets the pace; a byte is taken whenever a slot is free.
   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;

   // Classification of the incoming byte.
   always_comb begin
      len       = (cfg.frame_length < hsfe_pkg::LEN_W'(hsfe_pkg::HDR_LEN)) ?
                  hsfe_pkg::LEN_W'(hsfe_pkg::HDR_LEN) : cfg.frame_length;
      pos_next  = {1'b0, emitted_ff} + (hsfe_pkg::LEN_W+1)'(1);
      data_last = pos_next >= {1'b0, len};
      hdr_last  = len == hsfe_pkg::LEN_W'(hsfe_pkg::HDR_LEN);
      window    = {recent_ff[0], recent_ff[1], recent_ff[2], req.rx_byte};
      match     = (fill_ff == 2'd3) && (window == cfg.sync_header);
   end

   // Next state and queue command.
   always_comb begin
      recent_in   = recent_ff;
      fill_in     = fill_ff;
      in_frame_in = in_frame_ff;
      emitted_in  = emitted_ff;
      push.valid  = 1'b0;
      push.entry.kind = hsfe_pkg::ENTRY_DATA;
      push.entry.word = {{(hsfe_pkg::WORD_W-hsfe_pkg::BYTE_W){1'b0}}, req.rx_byte};
      push.entry.last = data_last;
      push.entry.pos  = emitted_ff;
      if (accept) begin
         priority if (in_frame_ff) begin
            push.valid = 1'b1;
            if (data_last) begin
               in_frame_in = 1'b0;
               emitted_in  = '0;
               fill_in     = '0;
            end else begin
               emitted_in = pos_next[hsfe_pkg::LEN_W-1:0];
            end
         end else if (match) begin
            push.valid      = 1'b1;
            push.entry.kind = hsfe_pkg::ENTRY_HEADER;
            push.entry.word = window;
            push.entry.last = hdr_last;
            push.entry.pos  = '0;
            fill_in         = '0;
            in_frame_in     = !hdr_last;
            emitted_in      = hdr_last ? '0 : hsfe_pkg::LEN_W'(hsfe_pkg::HDR_LEN);
         end else if (fill_ff == 2'd3) begin
            recent_in[0] = recent_ff[1];
            recent_in[1] = recent_ff[2];
            recent_in[2] = req.rx_byte;
         end else begin
            recent_in[fill_ff] = req.rx_byte;
            fill_in            = fill_ff + 2'd1;
         end
      end
   end

   // Window bytes are payload; only the counters and the mode are reset.
   always_ff @(posedge clock) begin
      recent_ff <= recent_in;
      if (reset) begin
         fill_ff     <= '0;
         in_frame_ff <= 1'b0;
         emitted_ff  <= '0;
      end else begin
         fill_ff     <= fill_in;
         in_frame_ff <= in_frame_in;
         emitted_ff  <= emitted_in;
      end
   end

endmodule

// ===== hw/rtl/hsfe_queue.sv =====
// Short command queue that decouples the front and back stages.
// Register-based circular buffer with a single read point. Depends on hsfe_pkg.
module hsfe_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  hsfe_pkg::q_slot_type   push,
   input  logic                   pop,
   output hsfe_pkg::q_slot_type   head,
   output hsfe_pkg::q_status_type status
);

   hsfe_pkg::q_entry_type             entries_ff [hsfe_pkg::QUEUE_DEPTH];
   logic [hsfe_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [hsfe_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [hsfe_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push, do_pop;

   assign status.full  = count_ff == hsfe_pkg::QCNT_W'(hsfe_pkg::QUEUE_DEPTH);
   assign status.count = count_ff;
   assign head.valid   = count_ff != '0;
   assign head.entry   = entries_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      do_push   = push.valid && !status.full;
      do_pop    = pop && head.valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == hsfe_pkg::QPTR_W'(hsfe_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + hsfe_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == hsfe_pkg::QPTR_W'(hsfe_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + hsfe_pkg::QPTR_W'(1);
      end
      count_in = count_ff + hsfe_pkg::QCNT_W'(do_push) - hsfe_pkg::QCNT_W'(do_pop);
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/hsfe_back.sv =====
// Back stage: expands queued commands into result items and holds them in an output register.
// A header command yields four items, a data command one. Depends on hsfe_pkg, hsfe_rsp_if.
module hsfe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  hsfe_pkg::q_slot_type head,
   output logic                 pop,
   hsfe_rsp_if.source           rsp
);

   logic [hsfe_pkg::BEAT_W-1:0] beat_ff, beat_in;
   logic                        out_valid_ff, out_valid_in;
   logic [hsfe_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic                        out_last_ff, out_last_in;
   logic [hsfe_pkg::LEN_W-1:0]  out_pos_ff, out_pos_in;
   logic                        load;
   logic                        final_beat;

   assign rsp.valid         = out_valid_ff;
   assign rsp.frame_byte    = out_byte_ff;
   assign rsp.frame_last    = out_last_ff;
   assign rsp.byte_position = out_pos_ff;

   // The output register refills whenever it is empty or being taken.
   always_comb begin
      load       = head.valid && (!out_valid_ff || rsp.ready);
      final_beat = (head.entry.kind == hsfe_pkg::ENTRY_DATA) ||
                   (beat_ff == hsfe_pkg::BEAT_W'(hsfe_pkg::HDR_LEN - 1));
      pop        = load && final_beat;
      beat_in    = beat_ff;
      if (load) begin
         beat_in = final_beat ? '0 : beat_ff + hsfe_pkg::BEAT_W'(1);
      end
      out_valid_in = load || (out_valid_ff && !rsp.ready);
   end

   // Byte, flag and position for the current beat.
   always_comb begin
      out_byte_in = head.entry.word[hsfe_pkg::BYTE_W-1:0];
      out_last_in = head.entry.last;
      out_pos_in  = head.entry.pos;
      if (head.entry.kind == hsfe_pkg::ENTRY_HEADER) begin
         unique case (beat_ff)
            2'd0:    out_byte_in = head.entry.word[31:24];
            2'd1:    out_byte_in = head.entry.word[23:16];
            2'd2:    out_byte_in = head.entry.word[15:8];
            default: out_byte_in = head.entry.word[7:0];
         endcase
         out_last_in = head.entry.last &&
                       (beat_ff == hsfe_pkg::BEAT_W'(hsfe_pkg::HDR_LEN - 1));
         out_pos_in  = {{(hsfe_pkg::LEN_W-hsfe_pkg::BEAT_W){1'b0}}, beat_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
         out_pos_ff  <= out_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
